### rtl/core/sic_pkg.sv
package sic_pkg;

  localparam int ValueW = 16;
  localparam int SizeW  = 7;
  localparam int RunW   = 7;
  localparam int OffW   = 9;
  localparam int SquareW = 2 * SizeW;

  localparam logic [SizeW-1:0] SizeReset = 7'd5;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  // Token that walks the ring chain, one cell per cycle
  typedef struct packed {
    logic              vld;
    logic              err;
    logic              found;
    logic [ValueW-1:0] m;
    logic [SizeW-1:0]  n;
    logic [ValueW-1:0] first;
    logic [SizeW-1:0]  ring;
    logic [RunW-1:0]   run;
    logic [OffW-1:0]   d;
  } ring_tok_t;

endpackage

### rtl/core/sic_in_if.sv
interface sic_in_if;
  logic                       valid;
  logic                       ready;
  logic [sic_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### rtl/core/sic_out_if.sv
interface sic_out_if;
  logic                      valid;
  logic                      ready;
  logic [sic_pkg::SizeW-1:0] row;
  logic [sic_pkg::SizeW-1:0] column;
  logic                      out_of_range;

  modport source (output valid, output row, output column, output out_of_range, input ready);
  modport sink (input valid, input row, input column, input out_of_range, output ready);
endinterface

### rtl/core/sic_ring_cell.sv
module sic_ring_cell #(
  parameter int RING = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  sic_pkg::ring_tok_t tok_in,
  output sic_pkg::ring_tok_t tok_out
);

  logic                       active;
  logic [sic_pkg::RunW-1:0]   run;
  logic [sic_pkg::OffW-1:0]   count;
  logic [sic_pkg::ValueW:0]   limit;
  sic_pkg::ring_tok_t         tok_next;

  // Ring RING has side run n - 2*RING + 1 and holds four runs
  assign active = tok_in.vld && !tok_in.err && !tok_in.found &&
                  (RING <= int'(tok_in.n >> 1));
  assign run    = tok_in.n - sic_pkg::RunW'(2 * RING - 1);
  assign count  = {run, 2'b00};
  assign limit  = {1'b0, tok_in.first} + (sic_pkg::ValueW + 1)'(count);

  always_comb begin
    tok_next = tok_in;
    if (active) begin
      if ({1'b0, tok_in.m} < limit) begin
        tok_next.found = 1'b1;
        tok_next.ring  = sic_pkg::SizeW'(RING);
        tok_next.run   = run;
        tok_next.d     = sic_pkg::OffW'(tok_in.m - tok_in.first);
      end else begin
        tok_next.first = tok_in.first + sic_pkg::ValueW'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

### rtl/core/sic_locate.sv
module sic_locate (
  input  sic_pkg::ring_tok_t        tok,
  output logic [sic_pkg::SizeW-1:0] row,
  output logic [sic_pkg::SizeW-1:0] column,
  output logic                      err
);

  logic [sic_pkg::OffW-1:0]  r1;
  logic [sic_pkg::OffW-1:0]  r2;
  logic [sic_pkg::OffW-1:0]  r3;
  logic [1:0]                side;
  logic [sic_pkg::OffW-1:0]  seat;
  logic [sic_pkg::SizeW-1:0] along;
  logic [sic_pkg::SizeW-1:0] far;
  logic [sic_pkg::SizeW-1:0] back;
  logic [sic_pkg::SizeW-1:0] centre;

  assign r1 = sic_pkg::OffW'(tok.run);
  assign r2 = r1 << 1;
  assign r3 = r2 + r1;

  always_comb begin
    priority if (tok.d < r1) begin
      side = sic_pkg::SIDE_TOP;
      seat = tok.d;
    end else if (tok.d < r2) begin
      side = sic_pkg::SIDE_RIGHT;
      seat = tok.d - r1;
    end else if (tok.d < r3) begin
      side = sic_pkg::SIDE_BOTTOM;
      seat = tok.d - r2;
    end else begin
      side = sic_pkg::SIDE_LEFT;
      seat = tok.d - r3;
    end
  end

  assign along  = sic_pkg::SizeW'(seat) + tok.ring;
  assign far    = tok.n - tok.ring + 7'd1;
  assign back   = tok.n - along + 7'd1;
  assign centre = (tok.n >> 1) + 7'd1;
  assign err    = tok.err;

  always_comb begin
    if (tok.err) begin
      row    = '0;
      column = '0;
    end else if (!tok.found) begin
      // odd size: the last value sits in the centre cell
      row    = centre;
      column = centre;
    end else begin
      unique case (side)
        sic_pkg::SIDE_TOP: begin
          row    = tok.ring;
          column = along;
        end
        sic_pkg::SIDE_RIGHT: begin
          row    = along;
          column = far;
        end
        sic_pkg::SIDE_BOTTOM: begin
          row    = far;
          column = back;
        end
        default: begin
          row    = back;
          column = tok.ring;
        end
      endcase
    end
  end

endmodule

### rtl/core/spiral_index_to_coordinate.sv
// From an accepted request to a valid result the token passes one entry register,
// one register per ring cell of the chain, and one output register.
// One transaction in flight; the next request is accepted the cycle after the
// result is taken.
// Reset (rst, synchronous, active high) clears the chain and output valids and
// sets matrix_size to 5.
module spiral_index_to_coordinate #(
  parameter int MAX_SIZE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [sic_pkg::SizeW-1:0] cfg_data,
  sic_in_if.sink                    request,
  sic_out_if.source                 result
);

  localparam int NCELL = MAX_SIZE / 2;

  logic [sic_pkg::SizeW-1:0]   matrix_size;
  logic                        busy;
  logic                        accept;
  logic [sic_pkg::SquareW-1:0] square;
  logic                        bad;
  sic_pkg::ring_tok_t          head;
  sic_pkg::ring_tok_t          chain [NCELL+1];
  logic [sic_pkg::SizeW-1:0]   row_c;
  logic [sic_pkg::SizeW-1:0]   column_c;
  logic                        err_c;

  assign request.ready = !busy;
  assign accept        = request.valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= sic_pkg::SizeReset;
    end else if (cfg_write) begin
      matrix_size <= cfg_data;
    end
  end

  assign square = sic_pkg::SquareW'(matrix_size) * sic_pkg::SquareW'(matrix_size);
  assign bad    = (matrix_size == '0) || (int'(matrix_size) > MAX_SIZE) ||
                  (request.value == '0) ||
                  ({1'b0, request.value} > (sic_pkg::ValueW + 1)'(square));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (result.valid && result.ready) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.vld <= 1'b0;
    end else begin
      head.vld   <= accept;
      head.err   <= bad;
      head.found <= 1'b0;
      head.m     <= request.value;
      head.n     <= matrix_size;
      head.first <= sic_pkg::ValueW'(1);
      head.ring  <= '0;
      head.run   <= '0;
      head.d     <= '0;
    end
  end

  assign chain[0] = head;

  for (genvar k = 0; k < NCELL; k++) begin : g_ring
    sic_ring_cell #(
      .RING(k + 1)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[k]),
      .tok_out(chain[k+1])
    );
  end

  sic_locate u_locate (
    .tok   (chain[NCELL]),
    .row   (row_c),
    .column(column_c),
    .err   (err_c)
  );

  // hold the result until taken; only one transaction is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (chain[NCELL].vld) begin
      result.valid        <= 1'b1;
      result.row          <= row_c;
      result.column       <= column_c;
      result.out_of_range <= err_c;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule

### rtl/core/sic_checker.sv
module sic_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [sic_pkg::SizeW-1:0] row,
  input logic [sic_pkg::SizeW-1:0] column,
  input logic                      out_of_range
);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_of_range |-> row == '0 && column == '0)
    else $error("error result with nonzero coordinate");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_of_range |-> row != '0 && column != '0)
    else $error("valid result with zero coordinate");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request accepted while busy");

  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request ready while a result waits");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(row) && $stable(column) &&
    $stable(out_of_range))
    else $error("stalled result changed");

endmodule

bind spiral_index_to_coordinate sic_checker u_sic_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .row         (result.row),
  .column      (result.column),
  .out_of_range(result.out_of_range)
);
